// ===== hw/rtl/intercept_time_solver_assert.svh =====
// assertion macros shared by the solver rtl
`ifndef INTERCEPT_TIME_SOLVER_ASSERT_SVH
`define INTERCEPT_TIME_SOLVER_ASSERT_SVH

// same-cycle implication
`define ITS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ITS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/its_pkg.sv =====
package its_pkg;

   localparam int CW        = 24;
   localparam int TIME_W    = 32;
   localparam int THR_W     = 16;
   localparam int FRAC_W    = 16;
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

   localparam int DIF_W     = CW + 1;
   localparam int SUM_W     = 2 * CW + 4;
   localparam int A_W       = 2 * CW + 1;
   localparam int B_W       = 2 * CW + 3;
   localparam int C_W       = 2 * CW + 2;
   localparam int AMAG_W    = 2 * CW;
   localparam int BMAG_W    = 2 * CW + 2;
   localparam int AH        = AMAG_W / 2;
   localparam int BH        = BMAG_W / 2;
   localparam int CH        = C_W / 2;
   localparam int D_W       = 4 * CW + 6;
   localparam int SQ_W      = D_W / 2;
   localparam int SQ_REM_W  = SQ_W + 3;
   localparam int NUM_W     = 2 * CW + 4;
   localparam int DIV_REM_W = NUM_W + 1;
   localparam int NSH_W     = NUM_W + FRAC_W;
   localparam int LATENCY   = 6 + SQ_W + 1 + 1 + TIME_W + 1;

   // which root formula a transaction takes
   typedef enum logic [1:0] {
      CASE_NONE = 2'd0,
      CASE_LIN  = 2'd1,
      CASE_QC   = 2'd2,
      CASE_QA   = 2'd3
   } its_case_type;

   typedef struct packed {
      its_case_type             sel;
      logic [AMAG_W-1:0]        absa;
      logic [BMAG_W-1:0]        absb;
      logic [C_W-1:0]           c;
   } its_side_type;

endpackage

// ===== hw/rtl/its_isqrt.sv =====
module its_isqrt import its_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [D_W-1:0]    in_rad,
   input  its_side_type      in_side,
   output logic              out_valid,
   output logic [SQ_W-1:0]   out_root,
   output its_side_type      out_side
);

   logic [SQ_W-1:0]     valid_ff;
   logic [SQ_REM_W-1:0] rem_ff  [SQ_W];
   logic [SQ_W-1:0]     root_ff [SQ_W];
   logic [D_W-1:0]      rad_ff  [SQ_W];
   its_side_type        side_ff [SQ_W];
   logic [SQ_REM_W-1:0] rem_in  [SQ_W];
   logic [SQ_W-1:0]     root_in [SQ_W];
   logic [D_W-1:0]      rad_in  [SQ_W];
   its_side_type        side_in [SQ_W];

   // one result bit per stage, two radicand bits consumed per stage
   for (genvar k = 0; k < SQ_W; k++) begin : g_step
      logic [SQ_REM_W-1:0] src_rem;
      logic [SQ_W-1:0]     src_root;
      logic [D_W-1:0]      src_rad;
      its_side_type        src_side;
      logic [SQ_REM_W-1:0] cur;
      logic [SQ_REM_W-1:0] trial;
      logic                fits;
      if (k == 0) begin : g_first
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_rad  = in_rad;
         assign src_side = in_side;
      end else begin : g_next
         assign src_rem  = rem_ff[k-1];
         assign src_root = root_ff[k-1];
         assign src_rad  = rad_ff[k-1];
         assign src_side = side_ff[k-1];
      end
      assign cur        = {src_rem[SQ_REM_W-3:0], src_rad[D_W-1 -: 2]};
      assign trial      = SQ_REM_W'({src_root, 2'b01});
      assign fits       = cur >= trial;
      assign rem_in[k]  = fits ? cur - trial : cur;
      assign root_in[k] = {src_root[SQ_W-2:0], fits};
      assign rad_in[k]  = {src_rad[D_W-3:0], 2'b00};
      assign side_in[k] = src_side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[SQ_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SQ_W; k++) begin
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         rad_ff[k]  <= rad_in[k];
         side_ff[k] <= side_in[k];
      end
   end

   assign out_valid = valid_ff[SQ_W-1];
   assign out_root  = root_ff[SQ_W-1];
   assign out_side  = side_ff[SQ_W-1];

endmodule

// ===== hw/rtl/its_div.sv =====
module its_div import its_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [NUM_W-1:0]  in_den,
   input  logic              in_found,
   output logic              out_valid,
   output logic [TIME_W-1:0] out_quot,
   output logic              out_sat,
   output logic              out_found
);

   logic [NSH_W-1:0]     nsh;
   logic                 i_valid_ff;
   logic [DIV_REM_W-1:0] i_rem_ff;
   logic [DIV_REM_W-1:0] i_rem_in;
   logic [TIME_W-1:0]    i_low_ff;
   logic [NUM_W-1:0]     i_den_ff;
   logic                 i_sat_ff;
   logic                 i_sat_in;
   logic                 i_found_ff;

   logic [TIME_W-1:0]    valid_ff;
   logic [DIV_REM_W-1:0] rem_ff   [TIME_W];
   logic [TIME_W-1:0]    low_ff   [TIME_W];
   logic [TIME_W-1:0]    quot_ff  [TIME_W];
   logic [NUM_W-1:0]     den_ff   [TIME_W];
   logic                 sat_ff   [TIME_W];
   logic                 found_ff [TIME_W];
   logic [DIV_REM_W-1:0] rem_in   [TIME_W];
   logic [TIME_W-1:0]    low_in   [TIME_W];
   logic [TIME_W-1:0]    quot_in  [TIME_W];
   logic [NUM_W-1:0]     den_in   [TIME_W];
   logic                 sat_in   [TIME_W];
   logic                 found_in [TIME_W];

   // quotient reaches 2^TIME_W exactly when num >= den << FRAC_W
   assign nsh      = {in_num, {FRAC_W{1'b0}}};
   assign i_rem_in = DIV_REM_W'(nsh[NSH_W-1:TIME_W]);
   assign i_sat_in = NSH_W'(in_num) >= {in_den, {FRAC_W{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         i_valid_ff <= 1'b0;
      end else begin
         i_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      i_rem_ff   <= i_rem_in;
      i_low_ff   <= nsh[TIME_W-1:0];
      i_den_ff   <= in_den;
      i_sat_ff   <= i_sat_in;
      i_found_ff <= in_found;
   end

   for (genvar k = 0; k < TIME_W; k++) begin : g_step
      logic [DIV_REM_W-1:0] src_rem;
      logic [TIME_W-1:0]    src_low;
      logic [TIME_W-1:0]    src_quot;
      logic [NUM_W-1:0]     src_den;
      logic                 src_sat;
      logic                 src_found;
      logic [DIV_REM_W-1:0] cur;
      logic                 fits;
      if (k == 0) begin : g_first
         assign src_rem   = i_rem_ff;
         assign src_low   = i_low_ff;
         assign src_quot  = '0;
         assign src_den   = i_den_ff;
         assign src_sat   = i_sat_ff;
         assign src_found = i_found_ff;
      end else begin : g_next
         assign src_rem   = rem_ff[k-1];
         assign src_low   = low_ff[k-1];
         assign src_quot  = quot_ff[k-1];
         assign src_den   = den_ff[k-1];
         assign src_sat   = sat_ff[k-1];
         assign src_found = found_ff[k-1];
      end
      assign cur         = {src_rem[DIV_REM_W-2:0], src_low[TIME_W-1]};
      assign fits        = cur >= DIV_REM_W'(src_den);
      assign rem_in[k]   = fits ? cur - DIV_REM_W'(src_den) : cur;
      assign quot_in[k]  = {src_quot[TIME_W-2:0], fits};
      assign low_in[k]   = {src_low[TIME_W-2:0], 1'b0};
      assign den_in[k]   = src_den;
      assign sat_in[k]   = src_sat;
      assign found_in[k] = src_found;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[TIME_W-2:0], i_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < TIME_W; k++) begin
         rem_ff[k]   <= rem_in[k];
         low_ff[k]   <= low_in[k];
         quot_ff[k]  <= quot_in[k];
         den_ff[k]   <= den_in[k];
         sat_ff[k]   <= sat_in[k];
         found_ff[k] <= found_in[k];
      end
   end

   assign out_valid = valid_ff[TIME_W-1];
   assign out_quot  = quot_ff[TIME_W-1];
   assign out_sat   = sat_ff[TIME_W-1];
   assign out_found = found_ff[TIME_W-1];

endmodule

// ===== hw/rtl/intercept_time_solver.sv =====
// a result passes stages 1-6, the square root, stage 7, the divider and the output register
// throughput: one transaction per cycle; busy is low except during reset
// the depth is set by the square-root pipeline (one root bit per stage) and the
// divider pipeline (one quotient bit per stage); results cannot be stalled
// reset is synchronous: it empties the pipeline and sets the threshold to 1
`include "intercept_time_solver_assert.svh"
module intercept_time_solver import its_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [CW-1:0]    req_shooter_x,
   input  logic signed [CW-1:0]    req_shooter_y,
   input  logic signed [CW-1:0]    req_shooter_z,
   input  logic signed [CW-1:0]    req_target_x,
   input  logic signed [CW-1:0]    req_target_y,
   input  logic signed [CW-1:0]    req_target_z,
   input  logic signed [CW-1:0]    req_target_vel_x,
   input  logic signed [CW-1:0]    req_target_vel_y,
   input  logic signed [CW-1:0]    req_target_vel_z,
   input  logic [CW-1:0]           req_projectile_speed,
   output logic                    rsp_strobe,
   output logic                    rsp_found,
   output logic [TIME_W-1:0]       rsp_intercept_time,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [THR_W-1:0]        csr_near_zero_threshold
);

   logic [THR_W-1:0] thr_ff;

   // stage 1: differences
   logic                    s1_valid_ff;
   logic signed [DIF_W-1:0] s1_dx_ff, s1_dy_ff, s1_dz_ff;
   logic signed [CW-1:0]    s1_vx_ff, s1_vy_ff, s1_vz_ff;
   logic [CW-1:0]           s1_spd_ff;

   // stage 2: products
   logic                        s2_valid_ff;
   logic signed [2*DIF_W-1:0]   s2_ddx_ff, s2_ddy_ff, s2_ddz_ff;
   logic signed [2*DIF_W-1:0]   s2_dvx_ff, s2_dvy_ff, s2_dvz_ff;
   logic signed [2*CW-1:0]      s2_vvx_ff, s2_vvy_ff, s2_vvz_ff;
   logic [2*CW-1:0]             s2_ss_ff;

   // stage 3: coefficients
   logic signed [SUM_W-1:0] c_sum, dot_sum, a_sum;
   logic                    s3_valid_ff;
   logic signed [A_W-1:0]   s3_a_ff;
   logic signed [B_W-1:0]   s3_b_ff;
   logic [C_W-1:0]          s3_c_ff;

   // stage 4: magnitudes, partial products, linear decision
   logic [A_W-1:0]          a_mag_full;
   logic [B_W-1:0]          b_mag_full;
   logic [AMAG_W-1:0]       a_mag;
   logic [BMAG_W-1:0]       b_mag;
   logic                    s4_valid_ff;
   logic [AMAG_W-1:0]       s4_absa_ff;
   logic [BMAG_W-1:0]       s4_absb_ff;
   logic [C_W-1:0]          s4_c_ff;
   logic                    s4_a_neg_ff, s4_b_neg_ff, s4_b_zero_ff, s4_c_zero_ff;
   logic                    s4_linear_ff, s4_lin_ok_ff;
   logic [2*BH-1:0]         s4_bhh_ff, s4_bhl_ff, s4_bll_ff;
   logic [AH+CH-1:0]        s4_ahch_ff, s4_ahcl_ff, s4_alch_ff, s4_alcl_ff;

   // stage 5: b squared and four a c
   logic                    s5_valid_ff;
   logic [D_W-1:0]          s5_b2_ff, s5_ac4_ff;
   logic [AMAG_W-1:0]       s5_absa_ff;
   logic [BMAG_W-1:0]       s5_absb_ff;
   logic [C_W-1:0]          s5_c_ff;
   logic                    s5_a_neg_ff, s5_b_neg_ff, s5_b_zero_ff, s5_c_zero_ff;
   logic                    s5_linear_ff, s5_lin_ok_ff;

   // stage 6: discriminant and case
   logic [D_W-1:0]          disc;
   its_side_type            s6_side_in;
   logic                    s6_valid_ff;
   logic [D_W-1:0]          s6_rad_ff;
   its_side_type            s6_side_ff;

   // square root
   logic                    sq_valid;
   logic [SQ_W-1:0]         sq_root;
   its_side_type            sq_side;

   // stage 7: operand select
   logic [NUM_W-1:0]        bq_sum;
   logic [NUM_W-1:0]        s7_num_in, s7_den_in;
   logic                    s7_valid_ff;
   logic [NUM_W-1:0]        s7_num_ff, s7_den_ff;
   logic                    s7_found_ff;

   // divider and output
   logic                    dv_valid;
   logic [TIME_W-1:0]       dv_quot;
   logic                    dv_sat;
   logic                    dv_found;
   logic                    out_valid_ff;
   logic                    out_found_ff;
   logic [TIME_W-1:0]       out_time_ff;
   logic [TIME_W-1:0]       out_time_in;

   assign busy      = reset;
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_near_zero_threshold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= start && !busy;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= sq_valid;
         out_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_dx_ff  <= DIF_W'(req_target_x) - DIF_W'(req_shooter_x);
      s1_dy_ff  <= DIF_W'(req_target_y) - DIF_W'(req_shooter_y);
      s1_dz_ff  <= DIF_W'(req_target_z) - DIF_W'(req_shooter_z);
      s1_vx_ff  <= req_target_vel_x;
      s1_vy_ff  <= req_target_vel_y;
      s1_vz_ff  <= req_target_vel_z;
      s1_spd_ff <= req_projectile_speed;
   end

   always_ff @(posedge clock) begin
      s2_ddx_ff <= s1_dx_ff * s1_dx_ff;
      s2_ddy_ff <= s1_dy_ff * s1_dy_ff;
      s2_ddz_ff <= s1_dz_ff * s1_dz_ff;
      s2_dvx_ff <= s1_dx_ff * s1_vx_ff;
      s2_dvy_ff <= s1_dy_ff * s1_vy_ff;
      s2_dvz_ff <= s1_dz_ff * s1_vz_ff;
      s2_vvx_ff <= s1_vx_ff * s1_vx_ff;
      s2_vvy_ff <= s1_vy_ff * s1_vy_ff;
      s2_vvz_ff <= s1_vz_ff * s1_vz_ff;
      s2_ss_ff  <= s1_spd_ff * s1_spd_ff;
   end

   assign c_sum   = SUM_W'(s2_ddx_ff) + SUM_W'(s2_ddy_ff) + SUM_W'(s2_ddz_ff);
   assign dot_sum = SUM_W'(s2_dvx_ff) + SUM_W'(s2_dvy_ff) + SUM_W'(s2_dvz_ff);
   assign a_sum   = SUM_W'(s2_vvx_ff) + SUM_W'(s2_vvy_ff) + SUM_W'(s2_vvz_ff)
                  - SUM_W'(s2_ss_ff);

   always_ff @(posedge clock) begin
      s3_a_ff <= a_sum[A_W-1:0];
      s3_b_ff <= {dot_sum[B_W-2:0], 1'b0};
      s3_c_ff <= c_sum[C_W-1:0];
   end

   assign a_mag_full = s3_a_ff[A_W-1] ? (~s3_a_ff + 1'b1) : s3_a_ff;
   assign b_mag_full = s3_b_ff[B_W-1] ? (~s3_b_ff + 1'b1) : s3_b_ff;
   assign a_mag      = a_mag_full[AMAG_W-1:0];
   assign b_mag      = b_mag_full[BMAG_W-1:0];

   always_ff @(posedge clock) begin
      s4_absa_ff   <= a_mag;
      s4_absb_ff   <= b_mag;
      s4_c_ff      <= s3_c_ff;
      s4_a_neg_ff  <= s3_a_ff[A_W-1];
      s4_b_neg_ff  <= s3_b_ff[B_W-1];
      s4_b_zero_ff <= (b_mag == '0);
      s4_c_zero_ff <= (s3_c_ff == '0);
      s4_linear_ff <= (a_mag == '0) || (a_mag < AMAG_W'(thr_ff));
      s4_lin_ok_ff <= (b_mag != '0) && (b_mag >= BMAG_W'(thr_ff)) && s3_b_ff[B_W-1]
                      && (s3_c_ff != '0);
      // split wide products into halves
      s4_bhh_ff  <= b_mag[BMAG_W-1:BH] * b_mag[BMAG_W-1:BH];
      s4_bhl_ff  <= b_mag[BMAG_W-1:BH] * b_mag[BH-1:0];
      s4_bll_ff  <= b_mag[BH-1:0] * b_mag[BH-1:0];
      s4_ahch_ff <= a_mag[AMAG_W-1:AH] * s3_c_ff[C_W-1:CH];
      s4_ahcl_ff <= a_mag[AMAG_W-1:AH] * s3_c_ff[CH-1:0];
      s4_alch_ff <= a_mag[AH-1:0] * s3_c_ff[C_W-1:CH];
      s4_alcl_ff <= a_mag[AH-1:0] * s3_c_ff[CH-1:0];
   end

   always_ff @(posedge clock) begin
      s5_b2_ff     <= (D_W'(s4_bhh_ff) << (2 * BH)) + (D_W'(s4_bhl_ff) << (BH + 1))
                      + D_W'(s4_bll_ff);
      s5_ac4_ff    <= ((D_W'(s4_ahch_ff) << (AH + CH)) + (D_W'(s4_ahcl_ff) << AH)
                      + (D_W'(s4_alch_ff) << CH) + D_W'(s4_alcl_ff)) << 2;
      s5_absa_ff   <= s4_absa_ff;
      s5_absb_ff   <= s4_absb_ff;
      s5_c_ff      <= s4_c_ff;
      s5_a_neg_ff  <= s4_a_neg_ff;
      s5_b_neg_ff  <= s4_b_neg_ff;
      s5_b_zero_ff <= s4_b_zero_ff;
      s5_c_zero_ff <= s4_c_zero_ff;
      s5_linear_ff <= s4_linear_ff;
      s5_lin_ok_ff <= s4_lin_ok_ff;
   end

   assign disc = s5_a_neg_ff ? s5_b2_ff + s5_ac4_ff : s5_b2_ff - s5_ac4_ff;

   always_comb begin
      s6_side_in.absa = s5_absa_ff;
      s6_side_in.absb = s5_absb_ff;
      s6_side_in.c    = s5_c_ff;
      s6_side_in.sel  = CASE_NONE;
      if (s5_linear_ff) begin
         if (s5_lin_ok_ff) begin
            s6_side_in.sel = CASE_LIN;
         end
      end else if (!disc[D_W-1]) begin
         if (!s5_a_neg_ff) begin
            if (s5_b_neg_ff) begin
               s6_side_in.sel = s5_c_zero_ff ? CASE_QA : CASE_QC;
            end
         end else if (!s5_b_neg_ff && !s5_b_zero_ff) begin
            s6_side_in.sel = CASE_QA;
         end else if (!s5_c_zero_ff) begin
            s6_side_in.sel = CASE_QC;
         end
      end
   end

   always_ff @(posedge clock) begin
      s6_rad_ff  <= disc[D_W-1] ? '0 : disc;
      s6_side_ff <= s6_side_in;
   end

   its_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s6_valid_ff),
      .in_rad    (s6_rad_ff),
      .in_side   (s6_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   assign bq_sum = NUM_W'(sq_side.absb) + NUM_W'(sq_root);

   always_comb begin
      case (sq_side.sel)
         CASE_LIN: begin
            s7_num_in = NUM_W'(sq_side.c);
            s7_den_in = NUM_W'(sq_side.absb);
         end
         CASE_QC: begin
            s7_num_in = NUM_W'({sq_side.c, 1'b0});
            s7_den_in = bq_sum;
         end
         CASE_QA: begin
            s7_num_in = bq_sum;
            s7_den_in = NUM_W'({sq_side.absa, 1'b0});
         end
         default: begin
            s7_num_in = '0;
            s7_den_in = NUM_W'(1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s7_num_ff   <= s7_num_in;
      s7_den_ff   <= s7_den_in;
      s7_found_ff <= (sq_side.sel != CASE_NONE);
   end

   its_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s7_valid_ff),
      .in_num    (s7_num_ff),
      .in_den    (s7_den_ff),
      .in_found  (s7_found_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_sat   (dv_sat),
      .out_found (dv_found)
   );

   assign out_time_in = !dv_found ? '0 : (dv_sat ? '1 : dv_quot);

   always_ff @(posedge clock) begin
      out_found_ff <= dv_found;
      out_time_ff  <= out_time_in;
   end

   assign rsp_strobe         = out_valid_ff;
   assign rsp_found          = out_found_ff;
   assign rsp_intercept_time = out_time_ff;

   `ITS_ASSERT_IMP(a_nf_zero_time, rsp_strobe && !rsp_found, rsp_intercept_time == '0, "time nonzero without intercept")
   `ITS_ASSERT_IMP(a_rsp_after_req, rsp_strobe, $past(start && !busy, LATENCY), "result without transaction")
   `ITS_ASSERT_IMP(a_den_nonzero, s7_valid_ff && s7_found_ff, s7_den_ff != '0, "zero divisor on found transaction")
   `ITS_ASSERT_NXT(a_neg_disc, s5_valid_ff && !s5_linear_ff && disc[D_W-1], s6_valid_ff && (s6_side_ff.sel == CASE_NONE), "negative discriminant not rejected")

endmodule
